// ===== sv/pressure_temperature_compensation_macros.svh =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_macros
// Assertion macros shared by the compensation block modules.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, constants and helpers of the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // configuration port
    localparam int CFG_IDX_W = 8;
    localparam int CAL_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_WORD_ONE   = 8'd0,
        CFG_CAL_WORD_TWO   = 8'd1,
        CFG_CAL_WORD_THREE = 8'd2,
        CFG_CAL_WORD_FOUR  = 8'd3
    } t_cfg_reg;

    // unpacked calibration coefficients
    typedef struct packed {
        logic [14:0] c1;
        logic [11:0] c2;
        logic [9:0]  c3;
        logic [9:0]  c4;
        logic [10:0] c5;
        logic [5:0]  c6;
    } t_coef;

    // stream widths
    localparam int RAW_W     = 16;
    localparam int RES_W     = 16;
    localparam int S_DATA_W  = 2 * RAW_W;
    localparam int M_DATA_W  = 4 * RES_W;

    // temperature difference from the reference reading, fits 18 bits signed
    localparam int DT_W      = 18;
    localparam int UT1_W     = 17;
    localparam logic [UT1_W-1:0] UT1_BASE = 17'd20224;

    // item handed from front to back
    typedef struct packed {
        logic [RAW_W-1:0]       d1;
        logic signed [DT_W-1:0] dt;
    } t_item;

    // second-order correction range
    typedef enum logic [1:0] {
        RANGE_MID,
        RANGE_COLD,
        RANGE_HOT
    } t_range;

    // arithmetic constants
    localparam logic signed [31:0] D1_OFFSET   = 32'sd7168;
    localparam logic signed [31:0] SENS_BASE   = 32'sd24576;
    localparam logic signed [31:0] C4_OFFSET   = 32'sd512;
    localparam logic signed [31:0] C6_T1_ADD   = 32'sd50;
    localparam logic signed [31:0] C6_T2_ADD   = 32'sd24;
    localparam logic signed [31:0] T_BASE      = 32'sd200;
    localparam logic signed [31:0] T_COLD_EDGE = 32'sd200;
    localparam logic signed [31:0] T_HOT_EDGE  = 32'sd450;
    localparam logic signed [31:0] P_BASE      = 32'sd2500;
    localparam logic signed [31:0] P_COLD_REF  = 32'sd3500;
    localparam logic signed [31:0] P_HOT_REF   = 32'sd10000;

    // division toward zero by 2**n of a signed 32-bit word
    function automatic logic signed [31:0] div_pow2(input logic signed [31:0] x,
                                                    input int unsigned n);
        logic signed [31:0] b;
        b = x;
        if (x[31]) begin
            b = x + ((32'sd1 <<< n) - 32'sd1);
        end
        return b >>> n;
    endfunction

endpackage

// ===== sv/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front
// Takes raw sample pairs, forms the temperature difference dT and hands the
// item to the queue; holds it while the queue is full.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_macros.svh"

module ptc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptc_pkg::t_coef            i_coef,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ptc_pkg::RAW_W-1:0] i_d1,
    input  logic [ptc_pkg::RAW_W-1:0] i_d2,
    input  logic                      i_full,
    output logic                      o_push,
    output ptc_pkg::t_item            o_item
);

    logic                              r_valid;
    ptc_pkg::t_item                    r_item;
    ptc_pkg::t_item                    n_item;
    logic [ptc_pkg::UT1_W-1:0]         w_ut1;
    logic                              w_accept;

    // reference reading ut1 = 8*c5 + 20224, dT = d2 - ut1
    always_comb begin
        w_ut1     = {3'b000, i_coef.c5, 3'b000} + ptc_pkg::UT1_BASE;
        n_item.d1 = i_d1;
        n_item.dt = $signed({2'b00, i_d2}) - $signed({1'b0, w_ut1});
    end

    // handshake: holding stage empties into the queue when it has room
    assign o_push   = r_valid && !i_full;
    assign o_ready  = !r_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    // a held request is never dropped while the queue is full
    `PTC_ASSERT_NXT(a_front_hold, i_clk, i_rst_n, r_valid && i_full, r_valid, "front request lost")

endmodule

// ===== sv/ptc_queue.sv =====
// ----------------------------------------------------------------------------
// ptc_queue
// Short register queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_macros.svh"

module ptc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ptc_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptc_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `PTC_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue overfilled")
    `PTC_ASSERT_IMP(a_q_pop, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `PTC_ASSERT_NXT(a_q_grow, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue count not advanced")

endmodule

// ===== sv/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back
// Nine-stage arithmetic pipeline: first-order temperature and pressure, then
// the cold/hot second-order correction. The last stage is the output register.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_macros.svh"

module ptc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptc_pkg::t_coef                i_coef,
    input  logic                          i_q_empty,
    input  ptc_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptc_pkg::M_DATA_W-1:0]  o_data
);

    localparam int STAGES = 9;

    logic [STAGES-1:0] r_vld;
    logic              w_en;

    // coefficients widened to signed words
    logic signed [31:0] w_c1, w_c2, w_c3, w_c4, w_c6;

    // stage 1: the three dT products
    logic signed [31:0] n_s1_mt, n_s1_moff, n_s1_msens, n_s1_d1m, w_dt;
    logic signed [31:0] r_s1_mt, r_s1_moff, r_s1_msens, r_s1_d1m;
    // stage 2: first-order temperature, offset, sensitivity
    logic signed [31:0] n_s2_t1w, n_s2_off, n_s2_sens;
    logic signed [31:0] r_s2_off, r_s2_sens, r_s2_d1m;
    logic [15:0]        r_s2_t1;
    // stage 3: sensitivity times pressure count
    logic signed [31:0] r_s3_prod, r_s3_off;
    logic [15:0]        r_s3_t1;
    // stage 4: x, range and distance from the range edge
    logic signed [31:0] n_s4_x, n_s4_dd, n_s4_k, w_t1s, w_c6k;
    ptc_pkg::t_range    n_s4_rng;
    logic signed [31:0] r_s4_x, r_s4_dd, r_s4_k;
    logic [15:0]        r_s4_t1;
    ptc_pkg::t_range    r_s4_rng;
    // stage 5: first-order pressure, squared distance
    logic signed [31:0] n_s5_p1w, n_s5_sq, w_x10;
    logic signed [31:0] r_s5_sq, r_s5_k;
    logic [15:0]        r_s5_p1, r_s5_t1;
    ptc_pkg::t_range    r_s5_rng;
    // stage 6: scaled square
    logic signed [31:0] r_s6_kt;
    logic [15:0]        r_s6_p1, r_s6_t1;
    ptc_pkg::t_range    r_s6_rng;
    // stage 7: t2 and the pressure correction operands
    logic signed [31:0] n_s7_t2, n_s7_pm, n_s7_pd, w_p1s;
    logic signed [31:0] r_s7_t2, r_s7_pm, r_s7_pd;
    logic [15:0]        r_s7_p1, r_s7_t1;
    ptc_pkg::t_range    r_s7_rng;
    // stage 8: pressure correction product
    logic signed [31:0] r_s8_prod, r_s8_t2;
    logic [15:0]        r_s8_p1, r_s8_t1;
    ptc_pkg::t_range    r_s8_rng;
    // stage 9: output register
    logic signed [31:0] n_p2;
    logic [15:0]        n_temp, n_pres;
    logic [15:0]        r_temp, r_pres, r_fo_temp, r_fo_pres;

    // whole pipeline moves unless the output holds an untaken result
    assign w_en    = !r_vld[STAGES-1] || i_ready;
    assign o_pop   = w_en && !i_q_empty;
    assign o_valid = r_vld[STAGES-1];
    assign o_data  = {r_fo_pres, r_fo_temp, r_pres, r_temp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], !i_q_empty};
        end
    end

    assign w_c1 = 32'(i_coef.c1);
    assign w_c2 = 32'(i_coef.c2);
    assign w_c3 = 32'(i_coef.c3);
    assign w_c4 = 32'(i_coef.c4);
    assign w_c6 = 32'(i_coef.c6);

    // stage 1 products
    always_comb begin
        w_dt       = 32'(i_item.dt);
        n_s1_mt    = w_dt * (w_c6 + ptc_pkg::C6_T1_ADD);
        n_s1_moff  = (w_c4 - ptc_pkg::C4_OFFSET) * w_dt;
        n_s1_msens = w_c3 * w_dt;
        n_s1_d1m   = $signed(32'(i_item.d1)) - ptc_pkg::D1_OFFSET;
    end

    // stage 2 first-order terms
    always_comb begin
        n_s2_t1w  = ptc_pkg::T_BASE + (r_s1_mt >>> 10);
        n_s2_off  = (w_c2 <<< 2) + (r_s1_moff >>> 14);
        n_s2_sens = w_c1 + (r_s1_msens >>> 10) + ptc_pkg::SENS_BASE;
    end

    // stage 4 range split
    always_comb begin
        n_s4_x = ptc_pkg::div_pow2(r_s3_prod, 14) - r_s3_off;
        w_t1s  = 32'(signed'(r_s3_t1));
        w_c6k  = w_c6 + ptc_pkg::C6_T2_ADD;
        priority if (w_t1s < ptc_pkg::T_COLD_EDGE) begin
            n_s4_rng = ptc_pkg::RANGE_COLD;
            n_s4_dd  = ptc_pkg::T_COLD_EDGE - w_t1s;
            n_s4_k   = (w_c6k <<< 3) + (w_c6k <<< 1) + w_c6k;
        end else if (w_t1s > ptc_pkg::T_HOT_EDGE) begin
            n_s4_rng = ptc_pkg::RANGE_HOT;
            n_s4_dd  = ptc_pkg::T_HOT_EDGE - w_t1s;
            n_s4_k   = (w_c6k <<< 1) + w_c6k;
        end else begin
            n_s4_rng = ptc_pkg::RANGE_MID;
            n_s4_dd  = '0;
            n_s4_k   = '0;
        end
    end

    // stage 5 first-order pressure and square
    always_comb begin
        w_x10    = (r_s4_x <<< 3) + (r_s4_x <<< 1);
        n_s5_p1w = ptc_pkg::div_pow2(w_x10, 5) + ptc_pkg::P_BASE;
        n_s5_sq  = r_s4_dd * r_s4_dd;
    end

    // stage 7 correction operands
    always_comb begin
        w_p1s = 32'(signed'(r_s6_p1));
        unique case (r_s6_rng)
            ptc_pkg::RANGE_COLD: begin
                n_s7_t2 = r_s6_kt >>> 20;
                n_s7_pm = (n_s7_t2 <<< 1) + n_s7_t2;
                n_s7_pd = w_p1s - ptc_pkg::P_COLD_REF;
            end
            ptc_pkg::RANGE_HOT: begin
                n_s7_t2 = r_s6_kt >>> 20;
                n_s7_pm = n_s7_t2;
                n_s7_pd = w_p1s - ptc_pkg::P_HOT_REF;
            end
            default: begin
                n_s7_t2 = '0;
                n_s7_pm = '0;
                n_s7_pd = '0;
            end
        endcase
    end

    // stage 9 final results
    always_comb begin
        unique case (r_s8_rng)
            ptc_pkg::RANGE_COLD: n_p2 = r_s8_prod >>> 14;
            ptc_pkg::RANGE_HOT:  n_p2 = r_s8_prod >>> 13;
            default:             n_p2 = '0;
        endcase
        n_temp = r_s8_t1 - r_s8_t2[15:0];
        n_pres = r_s8_p1 - n_p2[15:0];
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_mt    <= n_s1_mt;
            r_s1_moff  <= n_s1_moff;
            r_s1_msens <= n_s1_msens;
            r_s1_d1m   <= n_s1_d1m;

            r_s2_t1    <= n_s2_t1w[15:0];
            r_s2_off   <= n_s2_off;
            r_s2_sens  <= n_s2_sens;
            r_s2_d1m   <= r_s1_d1m;

            r_s3_prod  <= r_s2_sens * r_s2_d1m;
            r_s3_off   <= r_s2_off;
            r_s3_t1    <= r_s2_t1;

            r_s4_x     <= n_s4_x;
            r_s4_dd    <= n_s4_dd;
            r_s4_k     <= n_s4_k;
            r_s4_t1    <= r_s3_t1;
            r_s4_rng   <= n_s4_rng;

            r_s5_p1    <= n_s5_p1w[15:0];
            r_s5_sq    <= n_s5_sq;
            r_s5_k     <= r_s4_k;
            r_s5_t1    <= r_s4_t1;
            r_s5_rng   <= r_s4_rng;

            r_s6_kt    <= r_s5_k * r_s5_sq;
            r_s6_p1    <= r_s5_p1;
            r_s6_t1    <= r_s5_t1;
            r_s6_rng   <= r_s5_rng;

            r_s7_t2    <= n_s7_t2;
            r_s7_pm    <= n_s7_pm;
            r_s7_pd    <= n_s7_pd;
            r_s7_p1    <= r_s6_p1;
            r_s7_t1    <= r_s6_t1;
            r_s7_rng   <= r_s6_rng;

            r_s8_prod  <= r_s7_pm * r_s7_pd;
            r_s8_t2    <= r_s7_t2;
            r_s8_p1    <= r_s7_p1;
            r_s8_t1    <= r_s7_t1;
            r_s8_rng   <= r_s7_rng;

            r_temp     <= n_temp;
            r_pres     <= n_pres;
            r_fo_temp  <= r_s8_t1;
            r_fo_pres  <= r_s8_p1;
        end
    end

    `PTC_ASSERT_IMP(a_back_stall, i_clk, i_rst_n, !w_en, !o_pop, "queue popped during stall")
    `PTC_ASSERT_NXT(a_back_enter, i_clk, i_rst_n, o_pop, r_vld[0], "popped request not in pipeline")

endmodule

// ===== sv/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Barometric sensor compensation: first-order temperature and pressure from
// raw counts and calibration words, plus a cold/hot second-order correction.
//
//   channel  dir  handshake                  payload
//   s_*      in   s_tvalid / s_tready        s_tdata: raw_pressure, raw_temperature
//   m_*      out  m_tvalid / m_tready        m_tdata: four 16-bit results
//   cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per cycle sustained while m_tready is high; each passes the
// front register, the queue and nine pipeline stages to the output register.
// Reset clears valid flags, queue pointers and calibration words.
// A stalled m_tready freezes the back pipeline; the front keeps taking
// requests until its holding register and the QUEUE_DEPTH-entry queue fill.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptc_pkg::CAL_W-1:0]         i_cfg_data,
    // raw samples
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] raw_pressure, [31:16] raw_temperature
    input  logic [ptc_pkg::S_DATA_W-1:0]      s_tdata,
    // compensated results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] temperature, [31:16] pressure,
    // [47:32] first_order_temperature, [63:48] first_order_pressure
    output logic [ptc_pkg::M_DATA_W-1:0]      m_tdata
);

    logic [ptc_pkg::CAL_W-1:0] r_cal_one, r_cal_two, r_cal_three, r_cal_four;
    ptc_pkg::t_coef            w_coef;
    ptc_pkg::t_item            w_front_item, w_queue_item;
    logic                      w_push, w_full, w_pop, w_empty;

    assign o_cfg_ready = 1'b1;

    // calibration words; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_one   <= '0;
            r_cal_two   <= '0;
            r_cal_three <= '0;
            r_cal_four  <= '0;
        end else if (i_cfg_valid) begin
            unique case (ptc_pkg::t_cfg_reg'(i_cfg_index))
                ptc_pkg::CFG_CAL_WORD_ONE:   r_cal_one   <= i_cfg_data;
                ptc_pkg::CFG_CAL_WORD_TWO:   r_cal_two   <= i_cfg_data;
                ptc_pkg::CFG_CAL_WORD_THREE: r_cal_three <= i_cfg_data;
                ptc_pkg::CFG_CAL_WORD_FOUR:  r_cal_four  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient unpacking by fixed bit slices
    always_comb begin
        w_coef.c1 = r_cal_one[15:1];
        w_coef.c2 = {r_cal_three[5:0], r_cal_four[5:0]};
        w_coef.c3 = r_cal_four[15:6];
        w_coef.c4 = r_cal_three[15:6];
        w_coef.c5 = {r_cal_one[0], r_cal_two[15:6]};
        w_coef.c6 = r_cal_two[5:0];
    end

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (w_coef),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_d1    (s_tdata[15:0]),
        .i_d2    (s_tdata[31:16]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    ptc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    ptc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_coef    (w_coef),
        .i_q_empty (w_empty),
        .i_item    (w_queue_item),
        .o_pop     (w_pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_data    (m_tdata)
    );

endmodule

// ===== tb/sv/pressure_temperature_compensation_test.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_test
// Self-checking bench for the compensation block. A scoreboard class predicts
// the four 16-bit readings of every accepted request from its own copy of the
// calibration words. Directed requests hit the raw count extremes and the
// cold, mid and hot range edges. Random phases with changing calibration
// then follow, under random idling on both streams and two long output stalls.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_test;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int TIMEOUT_CYCLES   = 200000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int NUM_PHASES       = 10;
    localparam int ITEMS_PER_PHASE  = 175;
    localparam int STEADY_PHASE     = 3;
    localparam int IDLE_PERCENT     = 28;
    localparam int HOLD_CYCLES      = 80;
    localparam logic [ptc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED =
        ptc_pkg::CFG_CAL_WORD_FOUR + 1'b1;
    localparam logic [ptc_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = {ptc_pkg::CFG_IDX_W{1'b1}};

    // one compensated reading, laid out as on m_tdata
    typedef struct packed {
        logic [ptc_pkg::RES_W-1:0] first_order_pressure;
        logic [ptc_pkg::RES_W-1:0] first_order_temperature;
        logic [ptc_pkg::RES_W-1:0] pressure;
        logic [ptc_pkg::RES_W-1:0] temperature;
    } t_reading;

    // expected readings in acceptance order
    class compensation_board;
        logic [ptc_pkg::CAL_W-1:0] cal_one;
        logic [ptc_pkg::CAL_W-1:0] cal_two;
        logic [ptc_pkg::CAL_W-1:0] cal_three;
        logic [ptc_pkg::CAL_W-1:0] cal_four;
        t_reading                  readings_due[$];
        int                        errors;

        function new();
            cal_one   = '0;
            cal_two   = '0;
            cal_three = '0;
            cal_four  = '0;
            errors    = 0;
        endfunction

        function void write_cal(logic [ptc_pkg::CFG_IDX_W-1:0] index,
                                logic [ptc_pkg::CAL_W-1:0] value);
            case (index)
                ptc_pkg::CFG_CAL_WORD_ONE:   cal_one   = value;
                ptc_pkg::CFG_CAL_WORD_TWO:   cal_two   = value;
                ptc_pkg::CFG_CAL_WORD_THREE: cal_three = value;
                ptc_pkg::CFG_CAL_WORD_FOUR:  cal_four  = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] shift_signed(logic [31:0] v, int n);
            return $signed(v) >>> n;
        endfunction

        function logic [31:0] div_toward_zero(logic [31:0] v, int n);
            if (v[31]) begin
                v = v + ((32'd1 << n) - 32'd1);
            end
            return shift_signed(v, n);
        endfunction

        function logic [31:0] widen16(logic [31:0] v);
            return {{16{v[15]}}, v[15:0]};
        endfunction

        // raw temperature count of the reference point, from C5
        function logic [31:0] reference_count();
            return 32'd8 * {21'd0, cal_one[0], cal_two[15:6]} + 32'd20224;
        endfunction

        // first order values, then the cold or hot correction
        function t_reading compensate(logic [ptc_pkg::RAW_W-1:0] d1_raw,
                                      logic [ptc_pkg::RAW_W-1:0] d2_raw);
            logic [31:0] d1, d2, c1, c2, c3, c4, c6;
            logic [31:0] dt, t1, off, sens, x, p1, t2, p2, gap;
            t_reading    r;
            d1   = {16'd0, d1_raw};
            d2   = {16'd0, d2_raw};
            c1   = {17'd0, cal_one[15:1]};
            c2   = {20'd0, cal_three[5:0], cal_four[5:0]};
            c3   = {22'd0, cal_four[15:6]};
            c4   = {22'd0, cal_three[15:6]};
            c6   = {26'd0, cal_two[5:0]};
            dt   = d2 - reference_count();
            t1   = widen16(32'd200 + shift_signed(dt * (c6 + 32'd50), 10));
            off  = c2 * 32'd4 + shift_signed((c4 - 32'd512) * dt, 14);
            sens = c1 + shift_signed(c3 * dt, 10) + 32'd24576;
            x    = div_toward_zero(sens * (d1 - 32'd7168), 14) - off;
            p1   = widen16(div_toward_zero(x * 32'd10, 5) + 32'd2500);
            t2   = '0;
            p2   = '0;
            if ($signed(t1) < 32'sd200) begin
                gap = 32'd200 - t1;
                t2  = shift_signed(32'd11 * (c6 + 32'd24) * gap * gap, 20);
                p2  = shift_signed(32'd3 * t2 * (p1 - 32'd3500), 14);
            end else if ($signed(t1) > 32'sd450) begin
                gap = 32'd450 - t1;
                t2  = shift_signed(32'd3 * (c6 + 32'd24) * gap * gap, 20);
                p2  = shift_signed(t2 * (p1 - 32'd10000), 13);
            end
            r.temperature             = 16'(t1 - t2);
            r.pressure                = 16'(p1 - p2);
            r.first_order_temperature = t1[15:0];
            r.first_order_pressure    = p1[15:0];
            return r;
        endfunction

        function void note_sample(logic [ptc_pkg::RAW_W-1:0] d1_raw,
                                  logic [ptc_pkg::RAW_W-1:0] d2_raw);
            readings_due.push_back(compensate(d1_raw, d2_raw));
        endfunction

        function void check_field(string name, logic [ptc_pkg::RES_W-1:0] want,
                                  logic [ptc_pkg::RES_W-1:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            end
        endfunction

        function void check_reading(logic [ptc_pkg::M_DATA_W-1:0] data);
            t_reading got;
            t_reading want;
            got = data;
            if (readings_due.size() == 0) begin
                errors++;
                $error("unexpected reading %h", data);
                return;
            end
            want = readings_due.pop_front();
            check_field("temperature", want.temperature, got.temperature);
            check_field("pressure", want.pressure, got.pressure);
            check_field("first_order_temperature", want.first_order_temperature,
                        got.first_order_temperature);
            check_field("first_order_pressure", want.first_order_pressure,
                        got.first_order_pressure);
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [ptc_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [ptc_pkg::CAL_W-1:0]          i_cfg_data  = '0;
    logic                               s_tvalid    = 1'b0;
    logic                               s_tready;
    logic [ptc_pkg::S_DATA_W-1:0]       s_tdata     = '0;
    logic                               m_tvalid;
    logic                               m_tready    = 1'b0;
    logic [ptc_pkg::M_DATA_W-1:0]       m_tdata;

    compensation_board board;
    bit                steady = 1'b0;
    int                cycle_count = 0;

    pressure_temperature_compensation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("pressure_temperature_compensation_test: FAIL");
            $finish;
        end
    end

    // one calibration write; the caller lowers valid after the batch
    task automatic write_cal(input logic [ptc_pkg::CFG_IDX_W-1:0] index,
                             input logic [ptc_pkg::CAL_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_cal(index, value);
    endtask

    // one raw sample request with optional idle cycles ahead of it
    task automatic send_sample(input logic [ptc_pkg::RAW_W-1:0] d1,
                               input logic [ptc_pkg::RAW_W-1:0] d2);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        do @(posedge i_clk); while (!s_tready);
        board.note_sample(d1, d2);
    endtask

    task automatic wait_settled();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // result side: checks, random stalls and two long hold-offs
    initial begin : result_sink
        int hold_left;
        int results_seen;
        hold_left    = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                board.check_reading(m_tdata);
                results_seen++;
                if (results_seen == 160 || results_seen == 1000) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        ptc_pkg::t_cfg_reg         regs[4];
        logic [ptc_pkg::RAW_W-1:0] ref_d2;
        logic [ptc_pkg::RAW_W-1:0] d1;
        logic [ptc_pkg::RAW_W-1:0] d2;
        logic [ptc_pkg::CAL_W-1:0] word;
        board = new();
        regs  = '{ptc_pkg::CFG_CAL_WORD_ONE, ptc_pkg::CFG_CAL_WORD_TWO,
                  ptc_pkg::CFG_CAL_WORD_THREE, ptc_pkg::CFG_CAL_WORD_FOUR};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // calibration words still at reset: raw count extremes
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'd7168, 16'd20224);
        s_tvalid <= 1'b0;
        wait_settled();

        // nominal calibration: C1 2000, C2 660, C3 400, C4 300, C5 1000, C6 30;
        // writes to unused indexes must leave it alone
        write_cal(ptc_pkg::CFG_CAL_WORD_ONE, 16'd4000);
        write_cal(ptc_pkg::CFG_CAL_WORD_TWO, 16'd64030);
        write_cal(ptc_pkg::CFG_CAL_WORD_THREE, 16'd19210);
        write_cal(ptc_pkg::CFG_CAL_WORD_FOUR, 16'd25620);
        write_cal(CFG_IDX_UNUSED, 16'hFFFF);
        write_cal(CFG_IDX_TOP, 16'hFFFF);
        i_cfg_valid <= 1'b0;

        // edges of the cold, mid and hot ranges (t1 of 199, 200, 450, 451)
        ref_d2 = 16'(board.reference_count());
        send_sample(16'd7168, ref_d2 - 16'd1);
        send_sample(16'd7168, ref_d2);
        send_sample(16'd40000, ref_d2 + 16'd3212);
        send_sample(16'd40000, ref_d2 + 16'd3213);
        send_sample(16'd40000, ref_d2 - 16'd2000);
        send_sample(16'd40000, ref_d2 + 16'd6000);
        send_sample(16'h0000, ref_d2 + 16'd500);
        send_sample(16'hFFFF, ref_d2 + 16'd500);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h8000, 16'h8000);
        s_tvalid <= 1'b0;
        wait_settled();

        // random phases, each with its own calibration
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            foreach (regs[i]) begin
                if (ph < 2 || $urandom_range(3) != 0) begin
                    word = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : 16'($urandom);
                    write_cal(regs[i], word);
                end
            end
            if ($urandom_range(99) < 30) begin
                write_cal(8'($urandom_range(CFG_IDX_TOP, CFG_IDX_UNUSED)), 16'($urandom));
            end
            i_cfg_valid <= 1'b0;
            steady = (ph == STEADY_PHASE);
            ref_d2 = 16'(board.reference_count());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                d1 = 16'($urandom);
                // half of the temperatures near the reference point, where the
                // correction ranges change
                if ($urandom_range(1) == 0) begin
                    d2 = 16'($urandom);
                end else begin
                    d2 = ref_d2 + 16'(int'($urandom_range(12000)) - 4000);
                end
                send_sample(d1, d2);
            end
            s_tvalid <= 1'b0;
            steady = 1'b0;
            wait_settled();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("pressure_temperature_compensation_test: PASS");
        end else begin
            $display("pressure_temperature_compensation_test: FAIL");
        end
        $finish;
    end

endmodule
